FILE: sv/kfc_pkg.sv
// shared types and constants for the keypad calculator
package kfc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_OPERATOR,
		KIND_EQUALS,
		KIND_CLEAR
	} kind_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	localparam logic [3:0] DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] digit;
		logic [1:0] op;
	} key_t;

	typedef struct packed {
		logic signed [31:0] shown_value;
		logic               divide_error;
	} result_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic   done;
		value_t value;
	} alu_rsp_t;

endpackage

FILE: sv/kfc_alu.sv
// shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide
module kfc_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  kfc_pkg::alu_req_t req,
	input  kfc_pkg::value_t   a,
	input  kfc_pkg::value_t   b,
	output kfc_pkg::alu_rsp_t rsp
);
	import kfc_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	op_t              op_q;
	logic             neg_q;
	value_t           acc_q;
	value_t           x_q;
	value_t           y_q;
	value_t           res_q;

	logic [VALUE_WIDTH:0] shl;
	logic [VALUE_WIDTH:0] diff;
	logic                 fits;
	logic                 long_op;

	// one restoring divide step: shift in next dividend bit, try subtract
	always_comb begin
		shl     = {acc_q, x_q[VALUE_WIDTH-1]};
		diff    = shl - {1'b0, y_q};
		fits    = (shl >= {1'b0, y_q});
		long_op = (req.op == OP_MUL) || (req.op == OP_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_ADD;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= long_op ? CNT_W'(VALUE_WIDTH) : '0;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
			case (req.op)
				OP_ADD: acc_q <= a + b;
				OP_SUB: acc_q <= a - b;
				OP_MUL: begin
					acc_q <= '0;
					x_q   <= a;
					y_q   <= b;
				end
				default: begin
					acc_q <= '0;
					x_q   <= a[VALUE_WIDTH-1] ? (-a) : a;
					y_q   <= b[VALUE_WIDTH-1] ? (-b) : b;
				end
			endcase
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				if (op_q == OP_DIV)
					res_q <= neg_q ? (-x_q) : x_q;
				else
					res_q <= acc_q;
			end else begin
				case (op_q)
					OP_MUL: begin
						acc_q <= acc_q + (y_q[0] ? x_q : '0);
						x_q   <= {x_q[VALUE_WIDTH-2:0], 1'b0};
						y_q   <= {1'b0, y_q[VALUE_WIDTH-1:1]};
					end
					OP_DIV: begin
						acc_q <= fits ? diff[VALUE_WIDTH-1:0] : shl[VALUE_WIDTH-1:0];
						x_q   <= {x_q[VALUE_WIDTH-2:0], fits};
					end
					default: ;
				endcase
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

FILE: sv/keypad_four_function_calculator.sv
// top level of the keypad calculator: key sequencer, operand state and display
//
// one key press per item, one display item back per key. for digit, operator, clear
// and equals keys that need no arithmetic the result item is offered in the cycle
// after accept; an equals that computes waits in S_CALC for the shared arithmetic
// unit, which adds or subtracts on start and retires one multiplier or quotient
// bit per cycle for multiply or divide, and the item is offered once the unit
// signals done. the key side stalls from accept until the result item has been
// taken, so one key is in flight at a time. the display is VALUE_WIDTH bits, shown
// sign-extended or truncated to 32 bits. divide by zero raises divide_error for
// that key and leaves operand and display as they were. operands wrap on digit
// entry and on arithmetic.
module keypad_four_function_calculator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_valid,
	output logic             key_stall,
	input  kfc_pkg::key_t    key,
	output logic             result_valid,
	input  logic             result_stall,
	output kfc_pkg::result_t result
);
	import kfc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_SHOW
	} state_t;

	state_t state_q;
	value_t first_q;
	value_t second_q;
	op_t    pend_op_q;
	logic   pend_none_q;
	logic   first_ent_q;
	logic   second_ent_q;
	value_t disp_q;
	logic   err_q;

	logic     accept;
	logic     run_calc;
	logic     div_zero;
	logic     can_calc;
	value_t   entry_src;
	value_t   entry_val;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	// handshake: one key at a time, result held in registers until taken
	assign key_stall           = (state_q != S_IDLE);
	assign accept              = key_valid && !key_stall;
	assign result_valid        = (state_q == S_SHOW);
	assign result.shown_value  = 32'(signed'(disp_q));
	assign result.divide_error = err_q;

	always_comb begin
		// equals does arithmetic only with a nonzero first operand and an op pending
		can_calc  = (first_q != '0) && !pend_none_q;
		div_zero  = (pend_op_q == OP_DIV) && (second_q == '0);
		run_calc  = accept && (key.kind == KIND_EQUALS) && can_calc && !div_zero;
		// digit entry: value*10 + digit as (v<<3) + (v<<1) + digit, wrapping
		entry_src = pend_none_q ? first_q : second_q;
		entry_val = VALUE_WIDTH'({entry_src, 3'b000}) + VALUE_WIDTH'({entry_src, 1'b0})
			+ VALUE_WIDTH'(key.digit);
		alu_req.start = run_calc;
		alu_req.op    = pend_op_q;
	end

	kfc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (first_q),
		.b      (second_q),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_q      <= '0;
			second_q     <= '0;
			pend_op_q    <= OP_ADD;
			pend_none_q  <= 1'b1;
			first_ent_q  <= 1'b0;
			second_ent_q <= 1'b0;
			disp_q       <= '0;
			err_q        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						err_q   <= 1'b0;
						state_q <= S_SHOW;
						unique case (kind_t'(key.kind))
							KIND_DIGIT: begin
								// digits above nine are ignored
								if (key.digit <= DIGIT_MAX) begin
									disp_q <= entry_val;
									if (pend_none_q) begin
										first_q     <= entry_val;
										first_ent_q <= 1'b1;
									end else begin
										second_q     <= entry_val;
										second_ent_q <= 1'b1;
									end
								end
							end
							KIND_OPERATOR: begin
								// a new operator replaces the pending one
								pend_op_q   <= op_t'(key.op);
								pend_none_q <= 1'b0;
							end
							KIND_EQUALS: begin
								if (can_calc) begin
									if (div_zero)
										err_q <= 1'b1;
									else
										state_q <= S_CALC;
								end else if (!first_ent_q && second_ent_q) begin
									first_q <= second_q;
									disp_q  <= second_q;
								end
								// operands were latched by the unit on start
								first_ent_q  <= 1'b0;
								second_ent_q <= 1'b0;
								second_q     <= '0;
								pend_none_q  <= 1'b1;
							end
							KIND_CLEAR: begin
								first_q      <= '0;
								second_q     <= '0;
								pend_op_q    <= OP_ADD;
								pend_none_q  <= 1'b1;
								first_ent_q  <= 1'b0;
								second_ent_q <= 1'b0;
								disp_q       <= '0;
							end
						endcase
					end
				end
				S_CALC: begin
					// wait for the shared unit, then result becomes operand and display
					if (alu_rsp.done) begin
						first_q <= alu_rsp.value;
						disp_q  <= alu_rsp.value;
						state_q <= S_SHOW;
					end
				end
				S_SHOW: begin
					if (!result_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/kfc_chk.sv
// port-level checks for the keypad calculator and their binding
module kfc_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             key_valid,
	input logic             key_stall,
	input kfc_pkg::key_t    key,
	input logic             result_valid,
	input logic             result_stall,
	input kfc_pkg::result_t result
);
	import kfc_pkg::*;

	// an accepted key blocks the next one until its result is out
	a_busy_after_key: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall |=> key_stall)
		else $error("key side not stalled after an accepted item");

	// no new key while a result is waiting
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> key_stall)
		else $error("key taken while a result item is pending");

	// exactly one result per key: it goes away once taken
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall |=> !result_valid)
		else $error("result item repeated");

	// clear shows zero with no error on the next cycle
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key_stall && (key.kind == KIND_CLEAR) |=>
			result_valid && (result.shown_value == 32'sd0) && !result.divide_error)
		else $error("clear did not show zero");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind keypad_four_function_calculator kfc_chk u_kfc_chk (.*);

FILE: sim/calc_checker.sv
// watches the key and display channels, predicts each display item and compares
`timescale 1ns / 1ps

module calc_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             key_valid,
	input  logic             key_stall,
	input  kfc_pkg::key_t    key,
	input  logic             result_valid,
	input  logic             result_stall,
	input  kfc_pkg::result_t result,
	output int               fail_count,
	output int               pending_count
);
	import kfc_pkg::*;

	localparam value_t DECIMAL_BASE = 10;

	// calculator state as seen from the keypad
	value_t first_val;
	value_t second_val;
	value_t display_val;
	op_t    pending_op;
	logic   op_pending;
	logic   first_set;
	logic   second_set;

	result_t display_q[$];
	int      errors = 0;

	assign fail_count = errors;

	function automatic void clear_calc();
		first_val   = '0;
		second_val  = '0;
		display_val = '0;
		pending_op  = OP_ADD;
		op_pending  = 1'b0;
		first_set   = 1'b0;
		second_set  = 1'b0;
	endfunction

	// signed quotient truncated toward zero, done on magnitudes
	function automatic value_t trunc_quotient(input value_t num, input value_t den);
		value_t num_mag;
		value_t den_mag;
		value_t quo;
		num_mag = num[VALUE_WIDTH-1] ? -num : num;
		den_mag = den[VALUE_WIDTH-1] ? -den : den;
		quo = num_mag / den_mag;
		return (num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1]) ? -quo : quo;
	endfunction

	function automatic result_t calc_press(input key_t k);
		result_t shown;
		value_t  calc;
		logic    div_err;
		div_err = 1'b0;
		calc = '0;
		case (k.kind)
		KIND_DIGIT: begin
			if (k.digit <= DIGIT_MAX) begin
				if (!op_pending) begin
					first_val = first_val * DECIMAL_BASE + value_t'(k.digit);
					first_set = 1'b1;
					display_val = first_val;
				end else begin
					second_val = second_val * DECIMAL_BASE + value_t'(k.digit);
					second_set = 1'b1;
					display_val = second_val;
				end
			end
		end
		KIND_OPERATOR: begin
			pending_op = op_t'(k.op);
			op_pending = 1'b1;
		end
		KIND_EQUALS: begin
			if (first_val != '0 && op_pending) begin
				case (pending_op)
				OP_ADD: calc = first_val + second_val;
				OP_SUB: calc = first_val - second_val;
				OP_MUL: calc = first_val * second_val;
				default: begin
					if (second_val == '0)
						div_err = 1'b1;
					else
						calc = trunc_quotient(first_val, second_val);
				end
				endcase
				if (!div_err) begin
					first_val = calc;
					display_val = calc;
				end
			end else if (!first_set && second_set) begin
				first_val = second_val;
				display_val = second_val;
			end
			first_set = 1'b0;
			second_set = 1'b0;
			second_val = '0;
			op_pending = 1'b0;
		end
		default: clear_calc();
		endcase
		shown.shown_value = 32'($signed(display_val));
		shown.divide_error = div_err;
		return shown;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_calc();
			display_q.delete();
			pending_count <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (display_q.size() == 0) begin
					$error("unexpected display item: shown_value %0d divide_error %0b",
						result.shown_value, result.divide_error);
					errors++;
				end else begin
					want = display_q.pop_front();
					if (result.shown_value !== want.shown_value) begin
						$error("shown_value: expected %0d, actual %0d",
							want.shown_value, result.shown_value);
						errors++;
					end
					if (result.divide_error !== want.divide_error) begin
						$error("divide_error: expected %0b, actual %0b",
							want.divide_error, result.divide_error);
						errors++;
					end
				end
			end
			if (key_valid && !key_stall)
				display_q.push_back(calc_press(key));
			pending_count <= display_q.size();
		end
	end

endmodule

FILE: sim/testbench.sv
// top of the calculator testbench: clock, reset, key stimulus and verdict
`timescale 1ns / 1ps

module testbench;
	import kfc_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    key_valid = 1'b0;
	logic    key_stall;
	key_t    key = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int   fail_count;
	int   pending_count;
	logic key_taken = 1'b0;   // key accepted at the last rising edge
	int   keys_sent = 0;
	bit   idle_on = 1'b1;     // random gaps and stalls enabled
	int   stall_left = 0;

	always #5 clk = ~clk;

	keypad_four_function_calculator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.key_stall    (key_stall),
		.key          (key),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	calc_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_valid     (key_valid),
		.key_stall     (key_stall),
		.key           (key),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// sampled with the pre-edge values, read back at the next falling edge
	always @(posedge clk) begin
		key_taken <= key_valid && !key_stall;
	end

	// display side backpressure: random-length bursts of result stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// present one key and hold it until taken; called at a falling edge
	task automatic send_key(input key_t k);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			key_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		key_valid <= 1'b1;
		key <= k;
		do @(negedge clk); while (!key_taken);
		keys_sent++;
	endtask

	// don't-care fields get random bits so every input bit toggles
	task automatic press_digit(input int d);
		key_t k;
		k = key_t'($urandom);
		k.kind = KIND_DIGIT;
		k.digit = 4'(d);
		send_key(k);
	endtask

	task automatic press_op(input op_t o);
		key_t k;
		k = key_t'($urandom);
		k.kind = KIND_OPERATOR;
		k.op = o;
		send_key(k);
	endtask

	task automatic press(input kind_t kd);
		key_t k;
		k = key_t'($urandom);
		k.kind = kd;
		send_key(k);
	endtask

	task automatic press_number(input string digits);
		for (int i = 0; i < digits.len(); i++)
			press_digit(digits[i] - "0");
	endtask

	// random operand of n digits, mostly short, now and then long enough to wrap
	task automatic enter_operand();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
		repeat (n) press_digit($urandom_range(0, 9));
	endtask

	// well-formed calculation with random content
	task automatic calc_sequence();
		if ($urandom_range(0, 3) == 0)
			press(KIND_CLEAR);
		enter_operand();
		press_op(op_t'($urandom_range(0, 3)));
		// sometimes the operator gets replaced
		if ($urandom_range(0, 5) == 0)
			press_op(op_t'($urandom_range(0, 3)));
		enter_operand();
		press(KIND_EQUALS);
	endtask

	// stray keys: any kind, digits above nine included
	task automatic noise_burst();
		repeat ($urandom_range(1, 6)) send_key(key_t'($urandom));
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// digit above nine on a fresh calculator is ignored
		press(KIND_CLEAR);
		press_digit(15);
		// most negative value divided by minus one, both entered with wrap
		press_number("2147483648");
		press_op(OP_DIV);
		press_number("4294967295");
		press(KIND_EQUALS);
		// divide by zero keeps the operand and raises the error
		press_op(OP_DIV);
		press(KIND_EQUALS);
		// only the second operand entered: equals copies it into the first
		press(KIND_CLEAR);
		press_op(OP_ADD);
		press_number("70");
		press(KIND_EQUALS);
		// multiply then subtract chained through the first operand
		press_op(OP_MUL);
		press_digit(9);
		press(KIND_EQUALS);
		press_op(OP_SUB);
		press_number("999");
		press(KIND_EQUALS);

		while (keys_sent < 850) begin
			// the tail of the run goes without gaps or stalls
			if (keys_sent >= 750)
				idle_on = 1'b0;
			if ($urandom_range(0, 9) < 8)
				calc_sequence();
			else
				noise_burst();
		end
		key_valid <= 1'b0;

		while (pending_count != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
